// File: hdl/tegd_pkg.sv
// Shared types, codes and widths of the touch event gesture decoder.
`default_nettype none

package tegd_pkg;

	// Event field widths
	localparam int TYPE_W  = 16;
	localparam int CODE_W  = 16;
	localparam int VALUE_W = 32;
	localparam int GAIN_W  = 25;
	localparam int NORM_W  = 16;
	localparam int REG_IDX_W = 8;

	// Event codes that the decoder acts on
	localparam logic [TYPE_W-1:0] EV_ABS   = 16'd3;
	localparam logic [CODE_W-1:0] CODE_X   = 16'd53;
	localparam logic [CODE_W-1:0] CODE_Y   = 16'd54;
	localparam logic [CODE_W-1:0] CODE_TRK = 16'd57;

	// Coordinate / tracking id value that marks an unset start point or a release
	localparam logic signed [VALUE_W-1:0] POS_UNSET = -32'sd1;

	// Finger event kinds
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_DOWN   = 2'd0;
	localparam kind_t KIND_MOTION = 2'd1;
	localparam kind_t KIND_UP     = 2'd2;

	// Configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_X_GAIN = 8'd0;
	localparam logic [REG_IDX_W-1:0] REG_Y_GAIN = 8'd1;
	localparam logic [GAIN_W-1:0]    GAIN_RESET = 25'd8192;

	// Gain pair handed from the register file to the normalizer
	typedef struct packed {
		logic [GAIN_W-1:0] x;
		logic [GAIN_W-1:0] y;
	} gain_t;

	// Raw positions of one finger event, before normalization
	typedef struct packed {
		kind_t                     kind;
		logic signed [VALUE_W-1:0] origin_x;
		logic signed [VALUE_W-1:0] origin_y;
		logic signed [VALUE_W-1:0] cur_x;
		logic signed [VALUE_W-1:0] cur_y;
	} sample_t;

endpackage

`default_nettype wire

// File: hdl/tegd_if.sv
// Channel interfaces: raw touch events, finger events and configuration writes.
`default_nettype none

interface tegd_touch_if;
	logic                                 valid;
	logic                                 ready;
	logic [tegd_pkg::TYPE_W-1:0]          event_type;
	logic [tegd_pkg::CODE_W-1:0]          event_code;
	logic signed [tegd_pkg::VALUE_W-1:0]  event_value;

	modport source (output valid, event_type, event_code, event_value, input ready);
	modport sink   (input valid, event_type, event_code, event_value, output ready);
endinterface

interface tegd_finger_if;
	logic                                valid;
	logic                                ready;
	tegd_pkg::kind_t                     finger_kind;
	logic signed [tegd_pkg::NORM_W-1:0]  start_x_norm;
	logic signed [tegd_pkg::NORM_W-1:0]  start_y_norm;
	logic signed [tegd_pkg::NORM_W-1:0]  cur_x_norm;
	logic signed [tegd_pkg::NORM_W-1:0]  cur_y_norm;

	modport source (output valid, finger_kind, start_x_norm, start_y_norm,
		cur_x_norm, cur_y_norm, input ready);
	modport sink   (input valid, finger_kind, start_x_norm, start_y_norm,
		cur_x_norm, cur_y_norm, output ready);
endinterface

interface tegd_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [tegd_pkg::REG_IDX_W-1:0]     reg_index;
	logic [tegd_pkg::GAIN_W-1:0]        data;

	modport source (output valid, reg_index, data, input ready);
	modport sink   (input valid, reg_index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/tegd_cfg.sv
// Gain register file written through the configuration channel.
`default_nettype none

module tegd_cfg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	tegd_cfg_if.sink         cfg,
	output tegd_pkg::gain_t  gain
);

	tegd_pkg::gain_t gain_q;

	// Always take writes; unknown indexes are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q.x <= tegd_pkg::GAIN_RESET;
			gain_q.y <= tegd_pkg::GAIN_RESET;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				tegd_pkg::REG_X_GAIN: gain_q.x <= cfg.data;
				tegd_pkg::REG_Y_GAIN: gain_q.y <= cfg.data;
				default: ;
			endcase
		end
	end

	assign gain = gain_q;

endmodule

`default_nettype wire

// File: hdl/tegd_track.sv
// Input register and finger state tracker: turns raw events into finger samples.
`default_nettype none

module tegd_track (
	input  wire logic          clk,
	input  wire logic          arst_n,
	tegd_touch_if.sink         touch,
	output logic               smp_valid,
	input  wire logic          smp_ready,
	output tegd_pkg::sample_t  smp
);

	localparam int VW = tegd_pkg::VALUE_W;

	// Input register
	logic                         valid_s1;
	logic [tegd_pkg::TYPE_W-1:0]  type_s1;
	logic [tegd_pkg::CODE_W-1:0]  code_s1;
	logic signed [VW-1:0]         value_s1;

	// Finger state
	logic signed [VW-1:0] cur_x_q, cur_y_q, origin_x_q, origin_y_q;

	// Sample register
	logic               valid_s2;
	tegd_pkg::sample_t  sample_s2;

	logic en_s1, en_s2;
	logic signed [VW-1:0] cur_x_nx, cur_y_nx, origin_x_nx, origin_y_nx;
	tegd_pkg::kind_t kind;
	logic hit, x_set, y_set;

	// Stage enables: a stage loads when it is empty or its item moves on
	assign en_s2       = !valid_s2 || smp_ready;
	assign en_s1       = !valid_s1 || en_s2;
	assign touch.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= touch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && touch.valid) begin
			type_s1  <= touch.event_type;
			code_s1  <= touch.event_code;
			value_s1 <= touch.event_value;
		end
	end

	// Decode the event against the stored finger state
	always_comb begin
		cur_x_nx    = cur_x_q;
		cur_y_nx    = cur_y_q;
		origin_x_nx = origin_x_q;
		origin_y_nx = origin_y_q;
		kind        = tegd_pkg::KIND_DOWN;
		hit         = 1'b0;
		x_set       = (origin_x_q != tegd_pkg::POS_UNSET);
		y_set       = (origin_y_q != tegd_pkg::POS_UNSET);
		if (type_s1 == tegd_pkg::EV_ABS) begin
			case (code_s1)
				tegd_pkg::CODE_X: begin
					cur_x_nx = value_s1;
					hit      = y_set;
					if (!x_set) begin
						origin_x_nx = value_s1;
						kind        = tegd_pkg::KIND_DOWN;
					end else begin
						kind        = tegd_pkg::KIND_MOTION;
					end
				end
				tegd_pkg::CODE_Y: begin
					cur_y_nx = value_s1;
					hit      = x_set;
					if (!y_set) begin
						origin_y_nx = value_s1;
						kind        = tegd_pkg::KIND_DOWN;
					end else begin
						kind        = tegd_pkg::KIND_MOTION;
					end
				end
				tegd_pkg::CODE_TRK: begin
					if (value_s1 > 0) begin
						origin_x_nx = tegd_pkg::POS_UNSET;
						origin_y_nx = tegd_pkg::POS_UNSET;
					end else if (value_s1 == tegd_pkg::POS_UNSET) begin
						hit  = 1'b1;
						kind = tegd_pkg::KIND_UP;
					end
				end
				default: ;
			endcase
		end
	end

	// Update the finger state once per item as it leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			origin_x_q <= tegd_pkg::POS_UNSET;
			origin_y_q <= tegd_pkg::POS_UNSET;
		end else if (valid_s1 && en_s2) begin
			cur_x_q    <= cur_x_nx;
			cur_y_q    <= cur_y_nx;
			origin_x_q <= origin_x_nx;
			origin_y_q <= origin_y_nx;
		end
	end

	// Pass on only items that make a finger event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1 && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1 && hit) begin
			sample_s2.kind     <= kind;
			sample_s2.origin_x <= origin_x_nx;
			sample_s2.origin_y <= origin_y_nx;
			sample_s2.cur_x    <= cur_x_nx;
			sample_s2.cur_y    <= cur_y_nx;
		end
	end

	assign smp_valid = valid_s2;
	assign smp       = sample_s2;

endmodule

`default_nettype wire

// File: hdl/tegd_norm.sv
// Normalizer: gain multiply, rounding and Q1.15 saturation of the four positions.
`default_nettype none

module tegd_norm (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tegd_pkg::gain_t    gain,
	input  wire logic               smp_valid,
	output logic                    smp_ready,
	input  wire tegd_pkg::sample_t  smp,
	tegd_finger_if.source           finger
);

	localparam int VW     = tegd_pkg::VALUE_W;
	localparam int PROD_W = VW + tegd_pkg::GAIN_W + 1;
	localparam int SH     = 9;
	localparam int Q_W    = PROD_W - SH;
	localparam int T_W    = Q_W + 1;
	localparam logic signed [PROD_W-1:0] HALF   = PROD_W'(256);
	localparam logic signed [T_W-1:0]    OFFSET = T_W'(32768);
	localparam logic signed [T_W-1:0]    SAT_HI = T_W'(32767);
	localparam logic signed [T_W-1:0]    SAT_LO = T_W'(-32768);

	function automatic logic signed [PROD_W-1:0] mul_gain(
		input logic signed [VW-1:0] v, input logic [tegd_pkg::GAIN_W-1:0] g);
		return $signed(v) * $signed({1'b0, g});
	endfunction

	// Round to nearest, ties up: floor((p + 256) / 512)
	function automatic logic signed [T_W-1:0] round_q(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] r;
		r = (p + HALF) >>> SH;
		return T_W'($signed(r[Q_W-1:0]));
	endfunction

	function automatic logic [tegd_pkg::NORM_W-1:0] sat16(input logic signed [T_W-1:0] t);
		logic [tegd_pkg::NORM_W-1:0] res;
		if (t > SAT_HI) begin
			res = 16'h7fff;
		end else if (t < SAT_LO) begin
			res = 16'h8000;
		end else begin
			res = t[tegd_pkg::NORM_W-1:0];
		end
		return res;
	endfunction

	function automatic logic [tegd_pkg::NORM_W-1:0] norm_x(input logic signed [PROD_W-1:0] p);
		return sat16(round_q(p) - OFFSET);
	endfunction

	function automatic logic [tegd_pkg::NORM_W-1:0] norm_y(input logic signed [PROD_W-1:0] p);
		return sat16(OFFSET - round_q(p));
	endfunction

	// Product stage
	logic                     valid_s3;
	tegd_pkg::kind_t          kind_s3;
	logic signed [PROD_W-1:0] ox_s3, oy_s3, cx_s3, cy_s3;

	// Result register
	logic                              valid_s4;
	tegd_pkg::kind_t                   kind_s4;
	logic [tegd_pkg::NORM_W-1:0]       sx_s4, sy_s4, cx_s4, cy_s4;

	logic en_s3, en_s4;

	assign en_s4     = !valid_s4 || finger.ready;
	assign en_s3     = !valid_s3 || en_s4;
	assign smp_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s3) begin
				valid_s3 <= smp_valid;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// Multiply each position by its axis gain
	always_ff @(posedge clk) begin
		if (en_s3 && smp_valid) begin
			kind_s3 <= smp.kind;
			ox_s3   <= mul_gain(smp.origin_x, gain.x);
			oy_s3   <= mul_gain(smp.origin_y, gain.y);
			cx_s3   <= mul_gain(smp.cur_x, gain.x);
			cy_s3   <= mul_gain(smp.cur_y, gain.y);
		end
	end

	// Round, offset and saturate into the result register
	always_ff @(posedge clk) begin
		if (en_s4 && valid_s3) begin
			kind_s4 <= kind_s3;
			sx_s4   <= norm_x(ox_s3);
			sy_s4   <= norm_y(oy_s3);
			cx_s4   <= norm_x(cx_s3);
			cy_s4   <= norm_y(cy_s3);
		end
	end

	assign finger.valid        = valid_s4;
	assign finger.finger_kind  = kind_s4;
	assign finger.start_x_norm = sx_s4;
	assign finger.start_y_norm = sy_s4;
	assign finger.cur_x_norm   = cx_s4;
	assign finger.cur_y_norm   = cy_s4;

endmodule

`default_nettype wire

// File: hdl/touch_event_gesture_decoder.sv
// Top level of the touch event gesture decoder.
`default_nettype none

// Decodes raw multitouch events (type, code, value) into finger down, motion and
// up events carrying start and current positions in signed Q1.15. Only absolute
// axis events act: X and Y codes move the current point, and the first X and Y
// after a new tracking id set the start point and give finger down; a tracking id
// of -1 gives finger up. Positions are scaled by the x_gain and y_gain registers
// (round(2^25 / width) and round(2^25 / height)), rounded and saturated. The block
// takes one item per cycle while the finger channel does not stall, as stalls
// there hold the pipeline back; a finger event passes the input register, state
// tracker, gain multipliers and result register before it is offered. Gains
// must be written only while the block is idle; the block does not enforce it.
module touch_event_gesture_decoder (
	input wire logic       clk,
	input wire logic       arst_n,
	tegd_touch_if.sink     touch,
	tegd_finger_if.source  finger,
	tegd_cfg_if.sink       cfg
);

	tegd_pkg::gain_t    gain;
	tegd_pkg::sample_t  smp;
	logic               smp_valid;
	logic               smp_ready;

	tegd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.gain   (gain)
	);

	tegd_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.touch     (touch),
		.smp_valid (smp_valid),
		.smp_ready (smp_ready),
		.smp       (smp)
	);

	tegd_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.gain      (gain),
		.smp_valid (smp_valid),
		.smp_ready (smp_ready),
		.smp       (smp),
		.finger    (finger)
	);

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the touch event gesture decoder.
`default_nettype none

module testbench;

	// One raw touch event as the sender drives it
	typedef struct {
		logic [tegd_pkg::TYPE_W-1:0]         ev_type;
		logic [tegd_pkg::CODE_W-1:0]         code;
		logic signed [tegd_pkg::VALUE_W-1:0] value;
	} touch_item_t;

	// One finger event as the decoder should emit it
	typedef struct {
		tegd_pkg::kind_t                    kind;
		logic signed [tegd_pkg::NORM_W-1:0] start_x;
		logic signed [tegd_pkg::NORM_W-1:0] start_y;
		logic signed [tegd_pkg::NORM_W-1:0] cur_x;
		logic signed [tegd_pkg::NORM_W-1:0] cur_y;
	} finger_item_t;

	// One gain register write
	typedef struct {
		logic [tegd_pkg::REG_IDX_W-1:0] index;
		logic [tegd_pkg::GAIN_W-1:0]    data;
	} gain_write_t;

	logic clk = 1'b0;
	logic arst_n;

	tegd_touch_if  touch ();
	tegd_finger_if finger ();
	tegd_cfg_if    cfg ();

	touch_event_gesture_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.touch  (touch),
		.finger (finger),
		.cfg    (cfg)
	);

	// Traffic queues and counters
	touch_item_t  touch_backlog[$];
	finger_item_t pending_fingers[$];
	gain_write_t  gain_writes[$];
	int touches_queued = 0;
	int touches_taken  = 0;
	int gains_queued   = 0;
	int gains_written  = 0;
	int acted_items    = 0;
	int mismatches     = 0;
	bit touch_took     = 0;
	bit cfg_took       = 0;
	bit calm           = 0;

	// Mirror of the decoder state
	logic [tegd_pkg::GAIN_W-1:0]         gain_x  = tegd_pkg::GAIN_RESET;
	logic [tegd_pkg::GAIN_W-1:0]         gain_y  = tegd_pkg::GAIN_RESET;
	logic signed [tegd_pkg::VALUE_W-1:0] pos_x   = '0;
	logic signed [tegd_pkg::VALUE_W-1:0] pos_y   = '0;
	logic signed [tegd_pkg::VALUE_W-1:0] start_x = tegd_pkg::POS_UNSET;
	logic signed [tegd_pkg::VALUE_W-1:0] start_y = tegd_pkg::POS_UNSET;

	touch_item_t  sample;
	touch_item_t  next_touch;
	gain_write_t  next_gain;
	finger_item_t predicted;
	finger_item_t oldest;

	// Clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Scale a coordinate to Q1.15: round v*gain/2^9 with ties up, offset, saturate
	function automatic logic signed [tegd_pkg::NORM_W-1:0] norm_axis(
			input logic signed [tegd_pkg::VALUE_W-1:0] v,
			input logic [tegd_pkg::GAIN_W-1:0] gain, input bit flip);
		longint prod;
		longint q;
		longint t;
		prod = longint'(v) * longint'(gain) + 256;
		q = prod >>> 9;
		t = flip ? 32768 - q : q - 32768;
		if (t > 32767)
			t = 32767;
		else if (t < -32768)
			t = -32768;
		return t[tegd_pkg::NORM_W-1:0];
	endfunction

	// Advance the mirrored finger state by one event; return 1 if a finger item results
	function automatic bit decode_touch(input touch_item_t it, output finger_item_t ev);
		bit hit;
		tegd_pkg::kind_t k;
		hit = 0;
		k = tegd_pkg::KIND_DOWN;
		if (it.ev_type == tegd_pkg::EV_ABS) begin
			if (it.code == tegd_pkg::CODE_X) begin
				pos_x = it.value;
				if (start_x == tegd_pkg::POS_UNSET) begin
					start_x = it.value;
					if (start_y != tegd_pkg::POS_UNSET) begin
						hit = 1;
						k = tegd_pkg::KIND_DOWN;
					end
				end else if (start_y != tegd_pkg::POS_UNSET) begin
					hit = 1;
					k = tegd_pkg::KIND_MOTION;
				end
			end else if (it.code == tegd_pkg::CODE_Y) begin
				pos_y = it.value;
				if (start_y == tegd_pkg::POS_UNSET) begin
					start_y = it.value;
					if (start_x != tegd_pkg::POS_UNSET) begin
						hit = 1;
						k = tegd_pkg::KIND_DOWN;
					end
				end else if (start_x != tegd_pkg::POS_UNSET) begin
					hit = 1;
					k = tegd_pkg::KIND_MOTION;
				end
			end else if (it.code == tegd_pkg::CODE_TRK) begin
				if (it.value > 0) begin
					start_x = tegd_pkg::POS_UNSET;
					start_y = tegd_pkg::POS_UNSET;
				end else if (it.value == tegd_pkg::POS_UNSET) begin
					hit = 1;
					k = tegd_pkg::KIND_UP;
				end
			end
		end
		ev.kind    = k;
		ev.start_x = norm_axis(start_x, gain_x, 1'b0);
		ev.start_y = norm_axis(start_y, gain_y, 1'b1);
		ev.cur_x   = norm_axis(pos_x, gain_x, 1'b0);
		ev.cur_y   = norm_axis(pos_y, gain_y, 1'b1);
		return hit;
	endfunction

	function automatic void check_field(input string name,
			input logic [tegd_pkg::NORM_W-1:0] want,
			input logic [tegd_pkg::NORM_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name,
				$signed(want), $signed(got));
			mismatches++;
		end
	endfunction

	// Predict on accepted touch items, apply gain writes, check finger items
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.reg_index == tegd_pkg::REG_X_GAIN)
					gain_x = cfg.data;
				else if (cfg.reg_index == tegd_pkg::REG_Y_GAIN)
					gain_y = cfg.data;
				cfg_took = 1;
				gains_written++;
			end
			if (touch.valid && touch.ready) begin
				sample.ev_type = touch.event_type;
				sample.code    = touch.event_code;
				sample.value   = touch.event_value;
				if (decode_touch(sample, predicted))
					pending_fingers = {pending_fingers, predicted};
				touch_took = 1;
				touches_taken++;
			end
			if (finger.valid && finger.ready) begin
				if (pending_fingers.size() == 0) begin
					$display("%0t: unexpected finger item: expected none, got kind %0d",
						$time, finger.finger_kind);
					mismatches++;
				end else begin
					oldest = pending_fingers.pop_front();
					check_field("finger_kind", tegd_pkg::NORM_W'(oldest.kind),
						tegd_pkg::NORM_W'(finger.finger_kind));
					check_field("start_x_norm", oldest.start_x, finger.start_x_norm);
					check_field("start_y_norm", oldest.start_y, finger.start_y_norm);
					check_field("cur_x_norm", oldest.cur_x, finger.cur_x_norm);
					check_field("cur_y_norm", oldest.cur_y, finger.cur_y_norm);
				end
			end
		end
	end

	// Drive touch items, holding each until taken and idling at random
	always @(negedge clk) begin
		if (arst_n && (!touch.valid || touch_took)) begin
			touch_took = 0;
			if (touch_backlog.size() != 0 && (calm || $urandom_range(99) >= 31)) begin
				next_touch = touch_backlog.pop_front();
				touch.valid       <= 1'b1;
				touch.event_type  <= next_touch.ev_type;
				touch.event_code  <= next_touch.code;
				touch.event_value <= next_touch.value;
			end else begin
				touch.valid <= 1'b0;
			end
		end
	end

	// Stall the finger channel at random
	always @(negedge clk) begin
		if (arst_n)
			finger.ready <= calm || ($urandom_range(99) >= 31);
	end

	// Drive gain writes
	always @(negedge clk) begin
		if (arst_n && (!cfg.valid || cfg_took)) begin
			cfg_took = 0;
			if (gain_writes.size() != 0) begin
				next_gain = gain_writes.pop_front();
				cfg.valid     <= 1'b1;
				cfg.reg_index <= next_gain.index;
				cfg.data      <= next_gain.data;
			end else begin
				cfg.valid <= 1'b0;
			end
		end
	end

	task automatic push_touch(input logic [tegd_pkg::TYPE_W-1:0] t,
			input logic [tegd_pkg::CODE_W-1:0] c,
			input logic [tegd_pkg::VALUE_W-1:0] v);
		touch_item_t it;
		it.ev_type = t;
		it.code    = c;
		it.value   = v;
		touch_backlog = {touch_backlog, it};
		touches_queued++;
		if (t == tegd_pkg::EV_ABS && (c == tegd_pkg::CODE_X || c == tegd_pkg::CODE_Y ||
				c == tegd_pkg::CODE_TRK))
			acted_items++;
	endtask

	// Mostly screen-sized coordinates, some extremes, some anything
	function automatic logic [tegd_pkg::VALUE_W-1:0] pick_coord();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(0, 4095);
		if (r < 82) begin
			case ($urandom_range(3))
				0: return 32'h0000_0000;
				1: return tegd_pkg::POS_UNSET;
				2: return 32'h7FFF_FFFF;
				default: return 32'h8000_0000;
			endcase
		end
		return $urandom;
	endfunction

	// Push one stray or malformed event
	task automatic push_noise();
		logic [tegd_pkg::VALUE_W-1:0] v;
		case ($urandom_range(5))
			0: push_touch(tegd_pkg::TYPE_W'($urandom), tegd_pkg::CODE_W'($urandom), $urandom);
			1: push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_W'($urandom), $urandom);
			2: push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_TRK, '0);
			3: begin
				v = $urandom | 32'h8000_0000;
				if (v == tegd_pkg::POS_UNSET)
					v = 32'hFFFF_FFFE;
				push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_TRK, v);
			end
			4: push_touch(tegd_pkg::TYPE_W'($urandom_range(0, 2)),
				$urandom_range(0, 1) ? tegd_pkg::CODE_X : tegd_pkg::CODE_Y, pick_coord());
			default: push_touch(tegd_pkg::EV_ABS,
				$urandom_range(0, 1) ? tegd_pkg::CODE_X : tegd_pkg::CODE_Y, pick_coord());
		endcase
	endtask

	// Push a touch: mostly a new tracking id, first X and Y, some motion, mostly a release
	task automatic push_gesture();
		int moves;
		if ($urandom_range(99) < 90)
			push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_TRK, ($urandom_range(99) < 90) ?
				$urandom_range(1, 65535) : $urandom_range(1, 32'h7FFF_FFFF));
		if ($urandom_range(1)) begin
			push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_X, pick_coord());
			push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_Y, pick_coord());
		end else begin
			push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_Y, pick_coord());
			push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_X, pick_coord());
		end
		moves = $urandom_range(0, 6);
		repeat (moves) begin
			if ($urandom_range(99) < 10)
				push_noise();
			push_touch(tegd_pkg::EV_ABS,
				$urandom_range(1) ? tegd_pkg::CODE_X : tegd_pkg::CODE_Y, pick_coord());
		end
		if ($urandom_range(99) < 85)
			push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_TRK, tegd_pkg::POS_UNSET);
		if ($urandom_range(99) < 15)
			push_noise();
	endtask

	task automatic push_random(input int count);
		int first;
		first = acted_items;
		while (acted_items - first < count)
			push_gesture();
	endtask

	// Wait until every touch item is taken and every finger item has come, then let the pipe empty
	task automatic wait_drained();
		while (touches_taken != touches_queued || pending_fingers.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_gains(input logic [tegd_pkg::GAIN_W-1:0] gx,
			input logic [tegd_pkg::GAIN_W-1:0] gy);
		gain_write_t w;
		w.index = tegd_pkg::REG_X_GAIN;
		w.data  = gx;
		gain_writes = {gain_writes, w};
		w.index = tegd_pkg::REG_Y_GAIN;
		w.data  = gy;
		gain_writes = {gain_writes, w};
		gains_queued += 2;
		while (gains_written != gains_queued)
			@(negedge clk);
	endtask

	// Stimulus and end of run
	initial begin
		arst_n            = 1'b0;
		touch.valid       = 1'b0;
		touch.event_type  = '0;
		touch.event_code  = '0;
		touch.event_value = '0;
		finger.ready      = 1'b0;
		cfg.valid         = 1'b0;
		cfg.reg_index     = '0;
		cfg.data          = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Ignored types, codes and tracking ids
		push_touch(16'd2, tegd_pkg::CODE_X, 32'd100);
		push_touch(16'hFFFF, tegd_pkg::CODE_Y, 32'd100);
		push_touch(tegd_pkg::EV_ABS, 16'd0, 32'd5);
		push_touch(tegd_pkg::EV_ABS, 16'hFFFF, 32'hFFFF_FFFF);
		push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_TRK, 32'd0);
		push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_TRK, 32'hFFFF_FFFE);
		push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_TRK, 32'h8000_0000);
		// Press from reset, extreme coordinates, release
		push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_X, 32'd0);
		push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_Y, 32'd0);
		push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_X, 32'h7FFF_FFFF);
		push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_Y, 32'h8000_0000);
		push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_TRK, tegd_pkg::POS_UNSET);
		// Coordinate of -1 leaves the start point unset
		push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_TRK, 32'd1);
		push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_X, tegd_pkg::POS_UNSET);
		push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_Y, 32'd500);
		push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_X, tegd_pkg::POS_UNSET);
		push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_Y, 32'd1000);
		push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_TRK, tegd_pkg::POS_UNSET);
		// Release with no start point, then a Y of -1 before an X-first press
		push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_TRK, 32'h7FFF_FFFF);
		push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_TRK, tegd_pkg::POS_UNSET);
		push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_Y, tegd_pkg::POS_UNSET);
		push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_X, 32'd2000);
		push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_Y, 32'd100);
		push_touch(tegd_pkg::EV_ABS, tegd_pkg::CODE_TRK, tegd_pkg::POS_UNSET);
		wait_drained();

		set_gains(25'd1, 25'd16777216);
		push_random(150);
		wait_drained();

		set_gains(25'd16777216, 25'd1);
		push_random(150);
		wait_drained();

		// Zero gain pins X low and Y high
		set_gains(25'd0, 25'd0);
		push_random(60);
		wait_drained();

		// Full-rate stretch at a common screen size
		calm = 1;
		set_gains(25'd17476, 25'd31069);
		push_random(200);
		wait_drained();
		calm = 0;

		set_gains(tegd_pkg::GAIN_W'($urandom_range(1, 16777216)),
			tegd_pkg::GAIN_W'($urandom_range(1, 16777216)));
		push_random(200);
		wait_drained();

		set_gains(tegd_pkg::GAIN_RESET, tegd_pkg::GAIN_RESET);
		push_random(230);
		wait_drained();

		if (mismatches == 0)
			$display("PASS touch_event_gesture_decoder");
		else
			$display("FAIL touch_event_gesture_decoder");
		$finish;
	end

	// Give up on a hung run
	initial begin
		#1000000;
		$display("FAIL touch_event_gesture_decoder");
		$finish;
	end

endmodule

`default_nettype wire
